/* rtl/core/radial_dead_zone_gamepad_axes_macros.svh */
// assertion macros for the gamepad axis conditioning block
// used by the top level only, no other dependencies
`ifndef RADIAL_DEAD_ZONE_GAMEPAD_AXES_MACROS_SVH
`define RADIAL_DEAD_ZONE_GAMEPAD_AXES_MACROS_SVH

// condition that holds whenever the antecedent holds
`define RDZ_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// condition that holds in the cycle after the antecedent
`define RDZ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/rdz_pkg.sv */
// shared constants, register codes and result types for the gamepad axis block
// no dependencies
`default_nettype none

package rdz_pkg;

  localparam int STICK_FULL_SCALE_DEF   = 32767;
  localparam int TRIGGER_FULL_SCALE_DEF = 255;

  localparam int SQRT_STAGES   = 24;
  localparam int QUOT_W        = 15;
  localparam int STICK_LAT     = 4 + SQRT_STAGES + QUOT_W;
  localparam int TRIG_CORE_LAT = 2 + QUOT_W;
  localparam int TRIG_DELAY    = STICK_LAT - TRIG_CORE_LAT;

  localparam logic [14:0] ONE_Q14 = 15'd16384;

  localparam logic [14:0] LEFT_DZ_RESET  = 15'd7849;
  localparam logic [14:0] RIGHT_DZ_RESET = 15'd8689;
  localparam logic [7:0]  TRIG_THR_RESET = 8'd30;

  typedef enum logic [1:0] {
    REG_LEFT_DZ  = 2'd0,
    REG_RIGHT_DZ = 2'd1,
    REG_TRIG_THR = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic        moved;
    logic [15:0] dir_x;
    logic [15:0] dir_y;
    logic [14:0] level;
  } stick_res_t;

  typedef struct packed {
    logic        pressed;
    logic [14:0] level;
  } trig_res_t;

endpackage

`default_nettype wire

/* rtl/core/rdz_sqrt.sv */
// pipelined integer square root of a 32 bit value scaled by 2^16, one root bit per stage
// uses rdz_pkg
`default_nettype none

module rdz_sqrt #(
  parameter int TAG_W = 1
) (
  input  wire logic              clk,
  input  wire logic              en,
  input  wire logic [31:0]       radicand,
  input  wire logic [TAG_W-1:0]  tag_in,
  output logic      [23:0]       root,
  output logic      [TAG_W-1:0]  tag_out
);
  import rdz_pkg::*;

  logic [31:0]      rad_q   [SQRT_STAGES];
  logic [24:0]      rem_q   [SQRT_STAGES];
  logic [23:0]      root_q  [SQRT_STAGES];
  logic [TAG_W-1:0] tag_q   [SQRT_STAGES];

  logic [31:0]      rad_src  [SQRT_STAGES];
  logic [24:0]      rem_src  [SQRT_STAGES];
  logic [23:0]      root_src [SQRT_STAGES];
  logic [TAG_W-1:0] tag_src  [SQRT_STAGES];
  logic [47:0]      n_full   [SQRT_STAGES];
  logic [26:0]      rem_sh   [SQRT_STAGES];
  logic [26:0]      trial    [SQRT_STAGES];
  logic [24:0]      rem_next [SQRT_STAGES];
  logic [23:0]      root_next[SQRT_STAGES];

  always_comb begin
    for (int k = 0; k < SQRT_STAGES; k++) begin
      if (k == 0) begin
        rad_src[k]  = radicand;
        rem_src[k]  = '0;
        root_src[k] = '0;
        tag_src[k]  = tag_in;
      end else begin
        rad_src[k]  = rad_q[k-1];
        rem_src[k]  = rem_q[k-1];
        root_src[k] = root_q[k-1];
        tag_src[k]  = tag_q[k-1];
      end
      n_full[k] = {rad_src[k], 16'h0000};
      rem_sh[k] = {rem_src[k], n_full[k][47-2*k -: 2]};
      trial[k]  = {1'b0, root_src[k], 2'b01};
      if (rem_sh[k] >= trial[k]) begin
        rem_next[k]  = 25'(rem_sh[k] - trial[k]);
        root_next[k] = {root_src[k][22:0], 1'b1};
      end else begin
        rem_next[k]  = rem_sh[k][24:0];
        root_next[k] = {root_src[k][22:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < SQRT_STAGES; k++) begin
        rad_q[k]  <= rad_src[k];
        rem_q[k]  <= rem_next[k];
        root_q[k] <= root_next[k];
        tag_q[k]  <= tag_src[k];
      end
    end
  end

  assign root    = root_q[SQRT_STAGES-1];
  assign tag_out = tag_q[SQRT_STAGES-1];

endmodule

`default_nettype wire

/* rtl/core/rdz_div.sv */
// pipelined restoring divider, one quotient bit per stage, quotient known to fit QW bits
// no package dependencies
`default_nettype none

module rdz_div #(
  parameter int NW    = 38,
  parameter int DW    = 24,
  parameter int QW    = 15,
  parameter int TAG_W = 1
) (
  input  wire logic              clk,
  input  wire logic              en,
  input  wire logic [NW-1:0]     num,
  input  wire logic [DW-1:0]     den,
  input  wire logic [TAG_W-1:0]  tag_in,
  output logic      [QW-1:0]     quo,
  output logic      [TAG_W-1:0]  tag_out
);

  logic [NW-1:0]    num_q [QW];
  logic [DW-1:0]    den_q [QW];
  logic [DW-1:0]    rem_q [QW];
  logic [QW-1:0]    quo_q [QW];
  logic [TAG_W-1:0] tag_q [QW];

  logic [NW-1:0]    num_src  [QW];
  logic [DW-1:0]    den_src  [QW];
  logic [DW-1:0]    rem_src  [QW];
  logic [QW-1:0]    quo_src  [QW];
  logic [TAG_W-1:0] tag_src  [QW];
  logic [DW:0]      shifted  [QW];
  logic [DW-1:0]    rem_next [QW];
  logic [QW-1:0]    quo_next [QW];

  always_comb begin
    for (int k = 0; k < QW; k++) begin
      if (k == 0) begin
        num_src[k] = num;
        den_src[k] = den;
        rem_src[k] = DW'(num[NW-1:QW]);
        quo_src[k] = '0;
        tag_src[k] = tag_in;
      end else begin
        num_src[k] = num_q[k-1];
        den_src[k] = den_q[k-1];
        rem_src[k] = rem_q[k-1];
        quo_src[k] = quo_q[k-1];
        tag_src[k] = tag_q[k-1];
      end
      shifted[k] = {rem_src[k], num_src[k][QW-1-k]};
      if (shifted[k] >= {1'b0, den_src[k]}) begin
        rem_next[k] = DW'(shifted[k] - {1'b0, den_src[k]});
        quo_next[k] = {quo_src[k][QW-2:0], 1'b1};
      end else begin
        rem_next[k] = shifted[k][DW-1:0];
        quo_next[k] = {quo_src[k][QW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < QW; k++) begin
        num_q[k] <= num_src[k];
        den_q[k] <= den_src[k];
        rem_q[k] <= rem_next[k];
        quo_q[k] <= quo_next[k];
        tag_q[k] <= tag_src[k];
      end
    end
  end

  assign quo     = quo_q[QW-1];
  assign tag_out = tag_q[QW-1];

endmodule

`default_nettype wire

/* rtl/core/rdz_stick.sv */
// one stick lane: squares, square root, direction and level dividers
// uses rdz_pkg, rdz_sqrt and rdz_div
`default_nettype none

module rdz_stick #(
  parameter int FULL_SCALE = rdz_pkg::STICK_FULL_SCALE_DEF
) (
  input  wire logic               clk,
  input  wire logic               en,
  input  wire logic signed [15:0] x,
  input  wire logic signed [15:0] y,
  input  wire logic [14:0]        dz,
  output rdz_pkg::stick_res_t     res
);
  import rdz_pkg::*;

  localparam logic [14:0] FULL_W  = 15'(FULL_SCALE);
  localparam logic [22:0] FULL_Q8 = {FULL_W, 8'h00};

  // squares
  logic signed [31:0] xx_full, yy_full;
  logic [30:0] xx_q, yy_q;
  logic [15:0] ax_q, ay_q;
  logic        sx_q, sy_q;
  logic [29:0] dz_sq_q;

  assign xx_full = x * x;
  assign yy_full = y * y;

  always_ff @(posedge clk) begin
    dz_sq_q <= dz * dz;
    if (en) begin
      xx_q <= xx_full[30:0];
      yy_q <= yy_full[30:0];
      ax_q <= x[15] ? 16'(-x) : x;
      ay_q <= y[15] ? 16'(-y) : y;
      sx_q <= x[15];
      sy_q <= y[15];
    end
  end

  // sum and dead zone test
  logic [31:0] sum;
  logic [31:0] s_q;
  logic [34:0] tag1_q;

  assign sum = {1'b0, xx_q} + {1'b0, yy_q};

  always_ff @(posedge clk) begin
    if (en) begin
      s_q    <= sum;
      tag1_q <= {(sum > {2'b00, dz_sq_q}), sx_q, sy_q, ax_q, ay_q};
    end
  end

  logic [23:0] mag;
  logic [34:0] tag2;

  rdz_sqrt #(.TAG_W(35)) u_sqrt (
    .clk     (clk),
    .en      (en),
    .radicand(s_q),
    .tag_in  (tag1_q),
    .root    (mag),
    .tag_out (tag2)
  );

  // divider operands
  logic        moved2, sx2, sy2;
  logic [15:0] ax2, ay2;
  logic [22:0] capped, dz_q8, lvl_diff;
  logic        lvl_one;

  assign {moved2, sx2, sy2, ax2, ay2} = tag2;
  assign capped   = (mag < {1'b0, FULL_Q8}) ? mag[22:0] : FULL_Q8;
  assign dz_q8    = {dz, 8'h00};
  assign lvl_one  = (dz >= FULL_W);
  assign lvl_diff = (capped > dz_q8) ? 23'(capped - dz_q8) : 23'd0;

  logic [37:0] nx_q, ny_q, nl_q;
  logic [23:0] dm_q, dl_q;
  logic        sx_p, sy_p;
  logic [1:0]  fl_p;

  always_ff @(posedge clk) begin
    if (en) begin
      nx_q <= {ax2, 22'h0};
      ny_q <= {ay2, 22'h0};
      dm_q <= mag;
      nl_q <= {1'b0, lvl_diff, 14'h0};
      dl_q <= lvl_one ? 24'd1 : {1'b0, 15'(FULL_W - dz), 8'h00};
      sx_p <= sx2;
      sy_p <= sy2;
      fl_p <= {moved2, lvl_one};
    end
  end

  logic [QUOT_W-1:0] qx, qy, ql;
  logic              sx3, sy3;
  logic [1:0]        fl3;

  rdz_div #(.NW(38), .DW(24), .QW(QUOT_W), .TAG_W(1)) u_div_x (
    .clk(clk), .en(en), .num(nx_q), .den(dm_q), .tag_in(sx_p), .quo(qx), .tag_out(sx3)
  );

  rdz_div #(.NW(38), .DW(24), .QW(QUOT_W), .TAG_W(1)) u_div_y (
    .clk(clk), .en(en), .num(ny_q), .den(dm_q), .tag_in(sy_p), .quo(qy), .tag_out(sy3)
  );

  rdz_div #(.NW(38), .DW(24), .QW(QUOT_W), .TAG_W(2)) u_div_lvl (
    .clk(clk), .en(en), .num(nl_q), .den(dl_q), .tag_in(fl_p), .quo(ql), .tag_out(fl3)
  );

  // sign and dead zone masking
  always_ff @(posedge clk) begin
    if (en) begin
      res.moved <= fl3[1];
      res.dir_x <= !fl3[1] ? 16'd0 : (sx3 ? 16'(-{1'b0, qx}) : {1'b0, qx});
      res.dir_y <= !fl3[1] ? 16'd0 : (sy3 ? 16'(-{1'b0, qy}) : {1'b0, qy});
      res.level <= !fl3[1] ? 15'd0 : (fl3[0] ? ONE_Q14 : ql);
    end
  end

endmodule

`default_nettype wire

/* rtl/core/rdz_trigger.sv */
// one trigger lane: threshold test, level divider and delay to match the stick lanes
// uses rdz_pkg and rdz_div
`default_nettype none

module rdz_trigger #(
  parameter int FULL_SCALE = rdz_pkg::TRIGGER_FULL_SCALE_DEF
) (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire logic [7:0]    raw,
  input  wire logic [7:0]    thr,
  output rdz_pkg::trig_res_t res
);
  import rdz_pkg::*;

  localparam logic [7:0] FULL_W = 8'(FULL_SCALE);

  logic [7:0] capped, diff;
  logic       one;

  assign capped = (raw < FULL_W) ? raw : FULL_W;
  assign one    = (thr >= FULL_W);
  assign diff   = (capped > thr) ? 8'(capped - thr) : 8'd0;

  logic [21:0] num_q;
  logic [7:0]  den_q;
  logic [1:0]  fl_q;

  always_ff @(posedge clk) begin
    if (en) begin
      num_q <= {diff, 14'h0};
      den_q <= one ? 8'd1 : 8'(FULL_W - thr);
      fl_q  <= {(raw > thr), one};
    end
  end

  logic [QUOT_W-1:0] q;
  logic [1:0]        fl2;

  rdz_div #(.NW(22), .DW(8), .QW(QUOT_W), .TAG_W(2)) u_div (
    .clk(clk), .en(en), .num(num_q), .den(den_q), .tag_in(fl_q), .quo(q), .tag_out(fl2)
  );

  trig_res_t core_q;
  trig_res_t dly_q [TRIG_DELAY];

  always_ff @(posedge clk) begin
    if (en) begin
      core_q.pressed <= fl2[1];
      core_q.level   <= !fl2[1] ? 15'd0 : (fl2[0] ? ONE_Q14 : q);
      dly_q[0] <= core_q;
      for (int k = 1; k < TRIG_DELAY; k++) begin
        dly_q[k] <= dly_q[k-1];
      end
    end
  end

  assign res = dly_q[TRIG_DELAY-1];

endmodule

`default_nettype wire

/* rtl/core/radial_dead_zone_gamepad_axes.sv */
// Gamepad axis conditioning: radial dead zone on both sticks and threshold on both
// triggers. Fully pipelined, one sample per clock unless stalled; each stick lane
// passes its samples through the 24-stage square root followed by the 15-stage
// dividers. The whole pipeline stalls while a result waits on
// m_tready. Uses rdz_pkg, rdz_stick, rdz_trigger and the assertion macro header.
`default_nettype none

module radial_dead_zone_gamepad_axes #(
  parameter int STICK_FULL_SCALE   = rdz_pkg::STICK_FULL_SCALE_DEF,
  parameter int TRIGGER_FULL_SCALE = rdz_pkg::TRIGGER_FULL_SCALE_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // left_stick_x, left_stick_y, right_stick_x, right_stick_y,
  // left_trigger_raw, right_trigger_raw
  input  wire logic [79:0]  s_tdata,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // left_stick_moved, left_dir_x, left_dir_y, left_level,
  // right_stick_moved, right_dir_x, right_dir_y, right_level,
  // left_trigger_pressed, left_trigger_level, right_trigger_pressed, right_trigger_level
  output logic [127:0]      m_tdata,
  input  wire logic         cfg_wr_en,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [14:0]  cfg_wdata
);
  import rdz_pkg::*;
`include "radial_dead_zone_gamepad_axes_macros.svh"

  logic [14:0] left_dz, right_dz;
  logic [7:0]  trig_thr;

  always_ff @(posedge clk) begin
    if (rst) begin
      left_dz  <= LEFT_DZ_RESET;
      right_dz <= RIGHT_DZ_RESET;
      trig_thr <= TRIG_THR_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_reg_t'(cfg_index))
        REG_LEFT_DZ:  left_dz  <= cfg_wdata;
        REG_RIGHT_DZ: right_dz <= cfg_wdata;
        REG_TRIG_THR: trig_thr <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  logic [STICK_LAT-1:0] vld;
  logic                 en;

  assign en       = !vld[STICK_LAT-1] || m_tready;
  assign s_tready = en;
  assign m_tvalid = vld[STICK_LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[STICK_LAT-2:0], s_tvalid};
    end
  end

  stick_res_t left_res, right_res;
  trig_res_t  lt_res, rt_res;

  rdz_stick #(.FULL_SCALE(STICK_FULL_SCALE)) u_left (
    .clk(clk), .en(en), .x(s_tdata[15:0]), .y(s_tdata[31:16]), .dz(left_dz), .res(left_res)
  );

  rdz_stick #(.FULL_SCALE(STICK_FULL_SCALE)) u_right (
    .clk(clk), .en(en), .x(s_tdata[47:32]), .y(s_tdata[63:48]), .dz(right_dz),
    .res(right_res)
  );

  rdz_trigger #(.FULL_SCALE(TRIGGER_FULL_SCALE)) u_ltrig (
    .clk(clk), .en(en), .raw(s_tdata[71:64]), .thr(trig_thr), .res(lt_res)
  );

  rdz_trigger #(.FULL_SCALE(TRIGGER_FULL_SCALE)) u_rtrig (
    .clk(clk), .en(en), .raw(s_tdata[79:72]), .thr(trig_thr), .res(rt_res)
  );

  assign m_tdata = {rt_res.level, rt_res.pressed, lt_res.level, lt_res.pressed,
                    right_res.level, right_res.dir_y, right_res.dir_x, right_res.moved,
                    left_res.level, left_res.dir_y, left_res.dir_x, left_res.moved};

  `RDZ_ASSERT_IMP(a_left_idle_zero, clk, rst, m_tvalid && !m_tdata[0], m_tdata[47:1] == '0, "left stick fields set inside dead zone")
  `RDZ_ASSERT_IMP(a_right_idle_zero, clk, rst, m_tvalid && !m_tdata[48], m_tdata[95:49] == '0, "right stick fields set inside dead zone")
  `RDZ_ASSERT_IMP(a_trig_idle_zero, clk, rst, m_tvalid, (m_tdata[96] || m_tdata[111:97] == '0) && (m_tdata[112] || m_tdata[127:113] == '0), "trigger level set while not pressed")
  `RDZ_ASSERT_IMP(a_level_range, clk, rst, m_tvalid, m_tdata[47:33] <= ONE_Q14 && m_tdata[95:81] <= ONE_Q14 && m_tdata[111:97] <= ONE_Q14 && m_tdata[127:113] <= ONE_Q14, "level above full scale")
  `RDZ_ASSERT_NEXT(a_stall_hold, clk, rst, m_tvalid && !m_tready && !s_tready, m_tvalid, "result lost during stall")

endmodule

`default_nettype wire

/* bench/radial_dead_zone_gamepad_axes_tb.sv */
// testbench for the gamepad axis conditioning block: directed and random samples,
// each whole result word checked against an internal predictor; depends on rdz_pkg and the rtl
`default_nettype none

module radial_dead_zone_gamepad_axes_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rdz_pkg::*;

  localparam int STICK_FS = 32767;
  localparam int TRIG_FS  = 255;
  localparam int WATCHDOG = 20000;

  typedef struct packed {
    logic [7:0]  rt;
    logic [7:0]  lt;
    logic [15:0] ry;
    logic [15:0] rx;
    logic [15:0] ly;
    logic [15:0] lx;
  } sample_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [79:0]  s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [127:0] m_tdata;
  logic         cfg_wr_en = 1'b0;
  logic [1:0]   cfg_index = '0;
  logic [14:0]  cfg_wdata = '0;

  logic [127:0] expected_q[$];
  int           errors = 0;
  int           idle_cycles = 0;
  int           send_idle_pct = 0;
  int           recv_stall_pct = 0;
  int           hold_off = 0;
  logic [14:0]  left_dz, right_dz;
  logic [7:0]   trig_thr;

  radial_dead_zone_gamepad_axes DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #4 clk = ~clk;

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic logic [15:0] unit_dir(longint comp, longint unsigned mag);
    longint unsigned a, q;
    a = comp < 0 ? -comp : comp;
    q = (a << 22) / mag;
    if (comp < 0) q = 64'h10000 - q;
    return q[15:0];
  endfunction

  function automatic logic [47:0] stick_result(logic signed [15:0] x, logic signed [15:0] y,
                                               logic [14:0] dz);
    longint sx, sy;
    longint unsigned sq, mag, capped, lvl, d;
    logic [47:0] r;
    sx = x;
    sy = y;
    d = dz;
    sq = sx * sx + sy * sy;
    r = '0;
    if (sq <= d * d) return r;
    mag = int_sqrt(sq << 16);
    if (d >= STICK_FS) begin
      lvl = 16384;
    end else begin
      capped = mag < (64'(STICK_FS) << 8) ? mag : (64'(STICK_FS) << 8);
      if (capped <= (d << 8)) lvl = 0;
      else lvl = ((capped - (d << 8)) * 16384) / ((STICK_FS - d) << 8);
      if (lvl > 16384) lvl = 16384;
    end
    r = {lvl[14:0], unit_dir(sy, mag), unit_dir(sx, mag), 1'b1};
    return r;
  endfunction

  function automatic logic [15:0] trigger_result(logic [7:0] v, logic [7:0] t);
    int unsigned lvl;
    if (v <= t) return '0;
    if (t >= TRIG_FS) lvl = 16384;
    else lvl = ((v - t) * 16384) / (TRIG_FS - t);
    if (lvl > 16384) lvl = 16384;
    return {lvl[14:0], 1'b1};
  endfunction

  function automatic logic [127:0] condition_sample(sample_t s);
    logic [127:0] r;
    r = '0;
    r[47:0]    = stick_result(s.lx, s.ly, left_dz);
    r[95:48]   = stick_result(s.rx, s.ry, right_dz);
    r[111:96]  = trigger_result(s.lt, trig_thr);
    r[127:112] = trigger_result(s.rt, trig_thr);
    return r;
  endfunction

  task automatic send_sample(sample_t s);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= s;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    expected_q.push_back(condition_sample(s));
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (STICK_LAT + 10) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [14:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      REG_LEFT_DZ:  left_dz = val;
      REG_RIGHT_DZ: right_dz = val;
      default:      trig_thr = val[7:0];
    endcase
  endtask

  task automatic set_config(logic [14:0] l, logic [14:0] r, logic [7:0] t);
    drain();
    write_reg(REG_LEFT_DZ, l);
    write_reg(REG_RIGHT_DZ, r);
    write_reg(REG_TRIG_THR, {7'd0, t});
    cfg_wr_en <= 1'b0;
  endtask

  function automatic logic [15:0] rand_axis();
    case ($urandom_range(5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'($signed($urandom_range(2000)) - 1000);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic sample_t rand_sample();
    sample_t s;
    s.lx = rand_axis();
    s.ly = rand_axis();
    s.rx = rand_axis();
    s.ry = rand_axis();
    s.lt = $urandom_range(3) == 0 ? 8'(trig_thr + $urandom_range(1) ) : 8'($urandom);
    s.rt = 8'($urandom);
    return s;
  endfunction

  task automatic test_directed();
    logic [15:0] ax[5];
    ax = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff, 16'h1ea9};
    for (int i = 0; i < 5; i++)
      send_sample('{rt: 8'(i * 60), lt: 8'(255 - i * 50),
                    ry: ax[(i + 2) % 5], rx: ax[(i + 3) % 5],
                    ly: ax[(i + 1) % 5], lx: ax[i]});
    send_sample('{rt: 8'd31, lt: 8'd30, ry: 16'd0, rx: 16'd8690, ly: 16'd0, lx: 16'd7849});
    send_sample('{rt: 8'd255, lt: 8'd0, ry: 16'd0, rx: 16'd8689, ly: 16'd7850, lx: 16'd0});
    send_sample('{rt: 8'd29, lt: 8'd100, ry: 16'd6144, rx: 16'd6144,
                  ly: 16'hc000, lx: 16'hc000});
  endtask

  task automatic test_extreme_config();
    set_config(15'd0, 15'd32766, 8'd0);
    send_sample('{rt: 8'd1, lt: 8'd0, ry: 16'h8000, rx: 16'h8000, ly: 16'd0, lx: 16'd1});
    send_sample('{rt: 8'd255, lt: 8'd128, ry: 16'd0, rx: 16'h7fff, ly: 16'd0, lx: 16'd0});
    set_config(15'h7fff, 15'd0, 8'd254);
    send_sample('{rt: 8'd255, lt: 8'd254, ry: 16'd1, rx: 16'd0, ly: 16'h8000, lx: 16'h8000});
    set_config(15'd32767, 15'd32767, 8'd255);
    send_sample('{rt: 8'd255, lt: 8'd255, ry: 16'h8000, rx: 16'h8000,
                  ly: 16'h8000, lx: 16'h8000});
  endtask

  task automatic test_random_phases();
    int pct[4][2];
    pct = '{'{0, 0}, '{76, 0}, '{0, 76}, '{17, 17}};
    for (int p = 0; p < 4; p++) begin
      set_config(15'($urandom_range(32767)), 15'($urandom_range(32767)),
                 8'($urandom_range(255)));
      send_idle_pct  = pct[p][0];
      recv_stall_pct = pct[p][1];
      for (int i = 0; i < 220; i++) send_sample(rand_sample());
    end
    send_idle_pct  = 0;
    recv_stall_pct = 0;
  endtask

  task automatic test_backpressure();
    set_config(15'd7849, 15'd8689, 8'd30);
    hold_off = 300;
    for (int i = 0; i < 100; i++) send_sample(rand_sample());
    drain();
    for (int i = 0; i < 20; i++) send_sample(rand_sample());
  endtask

  always @(posedge clk) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= !(recv_stall_pct != 0 && $urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    logic [127:0] exp_res;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_q.size() == 0) begin
        $display("%0t unexpected result %h", $time, m_tdata);
        errors++;
      end else begin
        exp_res = expected_q.pop_front();
        if (exp_res !== m_tdata) begin
          $display("%0t mismatch expected %h actual %h", $time, exp_res, m_tdata);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || rst) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    left_dz  = LEFT_DZ_RESET;
    right_dz = RIGHT_DZ_RESET;
    trig_thr = TRIG_THR_RESET;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_extreme_config();
    test_random_phases();
    test_backpressure();
    drain();
    if (errors == 0 && expected_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
